// File: rtl/core/jbwe_pkg.sv
// ----------------------------------------------------------------------------
// jbwe_pkg
// Shared widths, register codes, reset values and types of the joystick
// bit word editor.
// ----------------------------------------------------------------------------
package jbwe_pkg;

  localparam int WORD_BITS     = 9;
  localparam int SAMPLE_BITS   = 12;
  localparam int REG_BITS      = 12;
  localparam int SUM_BITS      = SAMPLE_BITS + 2;
  localparam int CMP_BITS      = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
  localparam int SELECT_BITS   = (WORD_BITS > 2) ? $clog2(WORD_BITS) : 1;
  localparam int SEL_OUT_BITS  = 4;
  localparam int WORD_OUT_BITS = 9;
  localparam int IN_SAMPLES    = 6;
  localparam int IN_DATA_BITS  = ((IN_SAMPLES * SAMPLE_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = ((SEL_OUT_BITS + WORD_OUT_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [SELECT_BITS-1:0] SEL_LAST = SELECT_BITS'(WORD_BITS - 1);

  localparam logic [REG_BITS-1:0] X_SET_RESET   = REG_BITS'(3800);
  localparam logic [REG_BITS-1:0] X_CLEAR_RESET = REG_BITS'(500);
  localparam logic [REG_BITS-1:0] Y_HI_EN_RESET = REG_BITS'(3800);
  localparam logic [REG_BITS-1:0] Y_HI_EX_RESET = REG_BITS'(3600);
  localparam logic [REG_BITS-1:0] Y_LO_EN_RESET = REG_BITS'(500);
  localparam logic [REG_BITS-1:0] Y_LO_EX_RESET = REG_BITS'(700);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_SET      = 3'd0,
    CFG_X_CLEAR    = 3'd1,
    CFG_Y_HI_ENTER = 3'd2,
    CFG_Y_HI_EXIT  = 3'd3,
    CFG_Y_LO_ENTER = 3'd4,
    CFG_Y_LO_EXIT  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [REG_BITS-1:0] x_set;
    logic [REG_BITS-1:0] x_clear;
    logic [REG_BITS-1:0] y_hi_enter;
    logic [REG_BITS-1:0] y_hi_exit;
    logic [REG_BITS-1:0] y_lo_enter;
    logic [REG_BITS-1:0] y_lo_exit;
  } cfg_t;

  typedef struct packed {
    logic [SELECT_BITS-1:0] sel;
    logic                   high_zone;
    logic                   low_zone;
    logic [WORD_BITS-1:0]   word;
  } edit_state_t;

endpackage

// File: rtl/core/joystick_bit_word_editor_top.sv
// ----------------------------------------------------------------------------
// joystick_bit_word_editor_top
// Joystick driven editor of a small bit word.
//
// Each input beat on the s_ channel is one polling round: six samples in
// s_tdata and the Y and X present flags in s_tuser. Both axis means are
// worked out as the beat is taken and held in the input register. When
// that register advances, the Y zone logic and the X set or clear are
// applied to the editor state, and the new selection and word leave as one
// m_ beat. A result passes through the input register and then the result
// register, and one round is taken per cycle while m_tready stays high;
// the state update through the single result register sets that rate.
// When the receiver stalls, the result holds on m_tdata and one more round
// waits in the input register; s_tready then drops until the result is taken.
// Thresholds are written on the cfg_ channel, which is always ready; the user
// writes them only while the block is idle; the block does not enforce it.
// Reset restores the default thresholds, clears selection, zone flags and
// word, and empties both registers.
// ----------------------------------------------------------------------------
module joystick_bit_word_editor_top (
  input  logic                               clk,
  input  logic                               rst,
  // y_sample_a, y_sample_b, y_sample_c, x_sample_a, x_sample_b, x_sample_c
  input  logic [jbwe_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // y_valid, x_valid
  input  logic [jbwe_pkg::IN_USER_BITS-1:0]  s_tuser,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // selected_bit, bit_word
  output logic [jbwe_pkg::OUT_DATA_BITS-1:0] m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jbwe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [jbwe_pkg::REG_BITS-1:0]      cfg_data
);
  import jbwe_pkg::*;

  cfg_t                   cfg;
  logic [SAMPLE_BITS-1:0] y_mean_in;
  logic [SAMPLE_BITS-1:0] x_mean_in;
  logic [SAMPLE_BITS-1:0] y_mean;
  logic [SAMPLE_BITS-1:0] x_mean;
  logic                   y_valid;
  logic                   x_valid;
  logic                   in_full;
  logic                   advance;
  logic                   accept;
  edit_state_t            state;
  edit_state_t            state_next;

  assign cfg_ready = 1'b1;

  jbwe_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  jbwe_mean3 u_y_mean (
    .a    (s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS]),
    .b    (s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS]),
    .c    (s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]),
    .mean (y_mean_in)
  );

  jbwe_mean3 u_x_mean (
    .a    (s_tdata[3*SAMPLE_BITS +: SAMPLE_BITS]),
    .b    (s_tdata[4*SAMPLE_BITS +: SAMPLE_BITS]),
    .c    (s_tdata[5*SAMPLE_BITS +: SAMPLE_BITS]),
    .mean (x_mean_in)
  );

  jbwe_update u_update (
    .cur     (state),
    .cfg     (cfg),
    .y_mean  (y_mean),
    .y_valid (y_valid),
    .x_mean  (x_mean),
    .x_valid (x_valid),
    .nxt     (state_next)
  );

  assign advance  = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y_mean  <= y_mean_in;
      x_mean  <= x_mean_in;
      y_valid <= s_tuser[0];
      x_valid <= s_tuser[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      state    <= state_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = OUT_DATA_BITS'({WORD_OUT_BITS'(state.word), SEL_OUT_BITS'(state.sel)});

  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    state.sel <= SEL_LAST)
    else $error("selection out of range");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("editor state changed without a beat moving through");

  a_one_bit_edit: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(state.word ^ $past(state.word)) <= 1))
    else $error("more than one word bit changed in one round");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_full && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both registers are held");

endmodule

// File: rtl/core/jbwe_mean3.sv
// ----------------------------------------------------------------------------
// jbwe_mean3
// Truncated mean of three samples: the sum is divided by three through a
// reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module jbwe_mean3 (
  input  logic [jbwe_pkg::SAMPLE_BITS-1:0] a,
  input  logic [jbwe_pkg::SAMPLE_BITS-1:0] b,
  input  logic [jbwe_pkg::SAMPLE_BITS-1:0] c,
  output logic [jbwe_pkg::SAMPLE_BITS-1:0] mean
);
  import jbwe_pkg::*;

  localparam int DIV_SHIFT = SUM_BITS;
  localparam logic [SUM_BITS-1:0] DIV_MULT = SUM_BITS'((1 << DIV_SHIFT) / 3);

  logic [SUM_BITS-1:0]   sum;
  logic [2*SUM_BITS-1:0] prod;
  logic [SUM_BITS-1:0]   q_est;
  logic [SUM_BITS-1:0]   rem;
  logic [SUM_BITS-1:0]   q_fix;

  always_comb begin
    sum   = SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
    prod  = (2*SUM_BITS)'(sum) * (2*SUM_BITS)'(DIV_MULT);
    q_est = prod[2*SUM_BITS-1:DIV_SHIFT];
    rem   = sum - ((q_est << 1) + q_est);
    q_fix = (rem >= SUM_BITS'(3)) ? q_est + SUM_BITS'(1) : q_est;
    mean  = q_fix[SAMPLE_BITS-1:0];
  end

endmodule

// File: rtl/core/jbwe_cfg_regs.sv
// ----------------------------------------------------------------------------
// jbwe_cfg_regs
// Threshold register file. Writes to indexes past the last register are
// dropped.
// ----------------------------------------------------------------------------
module jbwe_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [jbwe_pkg::CFG_IDX_BITS-1:0] wr_index,
  input  logic [jbwe_pkg::REG_BITS-1:0]     wr_data,
  output jbwe_pkg::cfg_t                    cfg
);
  import jbwe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_set      <= X_SET_RESET;
      cfg.x_clear    <= X_CLEAR_RESET;
      cfg.y_hi_enter <= Y_HI_EN_RESET;
      cfg.y_hi_exit  <= Y_HI_EX_RESET;
      cfg.y_lo_enter <= Y_LO_EN_RESET;
      cfg.y_lo_exit  <= Y_LO_EX_RESET;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_X_SET:      cfg.x_set      <= wr_data;
        CFG_X_CLEAR:    cfg.x_clear    <= wr_data;
        CFG_Y_HI_ENTER: cfg.y_hi_enter <= wr_data;
        CFG_Y_HI_EXIT:  cfg.y_hi_exit  <= wr_data;
        CFG_Y_LO_ENTER: cfg.y_lo_enter <= wr_data;
        CFG_Y_LO_EXIT:  cfg.y_lo_exit  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/jbwe_update.sv
// ----------------------------------------------------------------------------
// jbwe_update
// Next editor state for one polling round: Y hysteresis zones move the
// selection, then the X mean sets or clears the selected word bit.
// ----------------------------------------------------------------------------
module jbwe_update (
  input  jbwe_pkg::edit_state_t             cur,
  input  jbwe_pkg::cfg_t                    cfg,
  input  logic [jbwe_pkg::SAMPLE_BITS-1:0]  y_mean,
  input  logic                              y_valid,
  input  logic [jbwe_pkg::SAMPLE_BITS-1:0]  x_mean,
  input  logic                              x_valid,
  output jbwe_pkg::edit_state_t             nxt
);
  import jbwe_pkg::*;

  logic [CMP_BITS-1:0]    y;
  logic [CMP_BITS-1:0]    x;
  logic [SELECT_BITS-1:0] sel_up;
  logic [WORD_BITS-1:0]   mask;

  always_comb begin
    y      = CMP_BITS'(y_mean);
    x      = CMP_BITS'(x_mean);
    nxt    = cur;
    sel_up = cur.sel;

    if (y_valid) begin
      if (!cur.high_zone && (y >= CMP_BITS'(cfg.y_hi_enter))) begin
        nxt.high_zone = 1'b1;
        sel_up = (cur.sel == SEL_LAST) ? '0 : cur.sel + SELECT_BITS'(1);
      end else if (cur.high_zone && (y < CMP_BITS'(cfg.y_hi_exit))) begin
        nxt.high_zone = 1'b0;
      end
      nxt.sel = sel_up;
      if (!cur.low_zone && (y <= CMP_BITS'(cfg.y_lo_enter))) begin
        nxt.low_zone = 1'b1;
        nxt.sel = (sel_up == '0) ? SEL_LAST : sel_up - SELECT_BITS'(1);
      end else if (cur.low_zone && (y > CMP_BITS'(cfg.y_lo_exit))) begin
        nxt.low_zone = 1'b0;
      end
    end

    mask = WORD_BITS'(1) << nxt.sel;
    if (x_valid) begin
      if (x >= CMP_BITS'(cfg.x_set)) begin
        nxt.word = cur.word | mask;
      end else if (x < CMP_BITS'(cfg.x_clear)) begin
        nxt.word = cur.word & ~mask;
      end
    end
  end

endmodule
